// ===== sv/bsem_pkg.sv =====
// ----------------------------------------------------------------------------
// bsem_pkg
// Shared types, widths, weight tables and helpers for the element matrix block.
// ----------------------------------------------------------------------------
package bsem_pkg;

  localparam int DataW = 32;               // raw field width
  localparam int DiffW = DataW + 1;        // absolute coordinate difference
  localparam int SqW   = 2 * DiffW;        // sum of two squared differences
  localparam int RemW  = DiffW + 3;        // square root remainder
  localparam int LenW  = 32;               // edge length after scaling
  localparam int ProdW = 2 * LenW;         // lx*lx, ly*ly, lx*ly
  localparam int D24W  = ProdW + 5;        // 24*lx*ly
  localparam int CoefW = DataW + 4;        // weighted coefficient sum
  localparam int AccW  = CoefW + ProdW + 2; // signed A*X + B*Y
  localparam int MagW  = AccW - 1;         // magnitude of that sum

  localparam logic [DataW-1:0] MaxPos = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] MinNeg = {1'b1, {(DataW-1){1'b0}}};

  // weights of k0..k3 on lx^2, times 24
  localparam int WX [4][4][4] = '{
    '{'{ 3, 1, 1, 3}, '{ 1, 1, 1, 1}, '{-1,-1,-1,-1}, '{-3,-1,-1,-3}},
    '{'{ 1, 1, 1, 1}, '{ 1, 3, 3, 1}, '{-1,-3,-3,-1}, '{-1,-1,-1,-1}},
    '{'{-1,-1,-1,-1}, '{-1,-3,-3,-1}, '{ 1, 3, 3, 1}, '{ 1, 1, 1, 1}},
    '{'{-3,-1,-1,-3}, '{-1,-1,-1,-1}, '{ 1, 1, 1, 1}, '{ 3, 1, 1, 3}}
  };

  // weights of k0..k3 on ly^2, times 24
  localparam int WY [4][4][4] = '{
    '{'{ 3, 3, 1, 1}, '{-3,-3,-1,-1}, '{-1,-1,-1,-1}, '{ 1, 1, 1, 1}},
    '{'{-3,-3,-1,-1}, '{ 3, 3, 1, 1}, '{ 1, 1, 1, 1}, '{-1,-1,-1,-1}},
    '{'{-1,-1,-1,-1}, '{ 1, 1, 1, 1}, '{ 1, 1, 3, 3}, '{-1,-1,-3,-3}},
    '{'{ 1, 1, 1, 1}, '{-1,-1,-1,-1}, '{-1,-1,-3,-3}, '{ 1, 1, 3, 3}}
  };

  typedef struct packed {
    logic signed [DataW-1:0] corner0_x;
    logic signed [DataW-1:0] corner0_y;
    logic signed [DataW-1:0] corner1_x;
    logic signed [DataW-1:0] corner1_y;
    logic signed [DataW-1:0] corner3_x;
    logic signed [DataW-1:0] corner3_y;
    logic signed [DataW-1:0] coeff_0;
    logic signed [DataW-1:0] coeff_1;
    logic signed [DataW-1:0] coeff_2;
    logic signed [DataW-1:0] coeff_3;
  } item_t;

  typedef struct packed {
    logic [1:0]              row_index;
    logic signed [DataW-1:0] entry_0;
    logic signed [DataW-1:0] entry_1;
    logic signed [DataW-1:0] entry_2;
    logic signed [DataW-1:0] entry_3;
    logic                    degenerate;
    logic                    saturated;
    logic                    last_row;
  } result_t;

  // element geometry handed from the front to the back
  typedef struct packed {
    logic                   degen;
    logic [ProdW-1:0]       x_sq;
    logic [ProdW-1:0]       y_sq;
    logic [D24W-1:0]        d24;
    logic [3:0][DataW-1:0]  k;
  } elem_t;

  // per-step control for the entry lanes
  typedef struct packed {
    logic load;
    logic mul;
    logic first;
    logic prep;
    logic div;
  } lane_ctrl_t;

  // weighted sum of the nodal coefficients for one matrix entry
  function automatic logic [CoefW-1:0] wsum(input logic [1:0] row, input logic [1:0] col,
                                            input logic [3:0][DataW-1:0] k,
                                            input logic use_y);
    logic [CoefW-1:0] acc;
    logic [CoefW-1:0] kv;
    int w;
    acc = '0;
    for (int i = 0; i < 4; i++) begin
      kv = CoefW'(signed'(k[i]));
      w  = use_y ? WY[row][col][i] : WX[row][col][i];
      case (w)
        1:       acc = acc + kv;
        -1:      acc = acc - kv;
        3:       acc = acc + kv + (kv << 1);
        -3:      acc = acc - kv - (kv << 1);
        default: acc = acc;
      endcase
    end
    return acc;
  endfunction

endpackage

// ===== sv/bsem_front.sv =====
// ----------------------------------------------------------------------------
// bsem_front
// Takes element requests, forms both edge lengths and their products.
// ----------------------------------------------------------------------------
module bsem_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  bsem_pkg::item_t item_i,
  output logic            elem_valid_o,
  input  logic            elem_ready_i,
  output bsem_pkg::elem_t elem_o
);
  import bsem_pkg::*;

  localparam logic [2:0] FIdle  = 3'd0;
  localparam logic [2:0] FSq    = 3'd1;
  localparam logic [2:0] FRoot  = 3'd2;
  localparam logic [2:0] FScale = 3'd3;
  localparam logic [2:0] FMul   = 3'd4;
  localparam logic [2:0] FPush  = 3'd5;

  localparam logic [5:0] RootLast = 6'(DiffW - 1);

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [DiffW-1:0] root;
  } root_t;

  function automatic logic [DiffW-1:0] abs_diff(input logic [DataW-1:0] a,
                                                input logic [DataW-1:0] b);
    logic [DiffW-1:0] d;
    d = DiffW'(signed'(a)) - DiffW'(signed'(b));
    return d[DiffW-1] ? DiffW'(-d) : d;
  endfunction

  // one digit of the restoring square root
  function automatic root_t root_step(input root_t cur, input logic [1:0] pair);
    root_t           nxt;
    logic [RemW-1:0] t;
    logic [RemW-1:0] trial;
    t     = {cur.rem[RemW-3:0], pair};
    trial = RemW'({cur.root, 2'b01});
    if (t >= trial) begin
      nxt.rem  = t - trial;
      nxt.root = {cur.root[DiffW-2:0], 1'b1};
    end else begin
      nxt.rem  = t;
      nxt.root = {cur.root[DiffW-2:0], 1'b0};
    end
    return nxt;
  endfunction

  logic [2:0]             state_q, state_d;
  logic [5:0]             cnt_q, cnt_d;
  logic [DiffW-1:0]       dx1_q, dy1_q, dx3_q, dy3_q;
  logic [3:0][DataW-1:0]  k_q;
  logic [SqW-1:0]         s1_q, s3_q;
  root_t                  r1_q, r3_q;
  logic [LenW-1:0]        lx_q, ly_q;
  logic [ProdW-1:0]       xsq_q, ysq_q, d_q;
  logic                   degen_q;

  logic [DiffW-1:0]       mul_a, mul_b;
  logic [SqW-1:0]         prod;
  logic                   scale_shift, degen;
  logic [LenW-1:0]        lx_s, ly_s;

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == FSq) begin
      case (cnt_q[1:0])
        2'd0:    begin mul_a = dx1_q; mul_b = dx1_q; end
        2'd1:    begin mul_a = dy1_q; mul_b = dy1_q; end
        2'd2:    begin mul_a = dx3_q; mul_b = dx3_q; end
        default: begin mul_a = dy3_q; mul_b = dy3_q; end
      endcase
    end else begin
      case (cnt_q[1:0])
        2'd0:    begin mul_a = DiffW'(lx_q); mul_b = DiffW'(lx_q); end
        2'd1:    begin mul_a = DiffW'(ly_q); mul_b = DiffW'(ly_q); end
        default: begin mul_a = DiffW'(lx_q); mul_b = DiffW'(ly_q); end
      endcase
    end
  end
  assign prod = mul_a * mul_b;

  // length scaling and zero length check
  always_comb begin
    degen       = (r1_q.root == '0) || (r3_q.root == '0);
    scale_shift = r1_q.root[DiffW-1] | r3_q.root[DiffW-1];
    lx_s = scale_shift ? r1_q.root[DiffW-1:1] : r1_q.root[LenW-1:0];
    ly_s = scale_shift ? r3_q.root[DiffW-1:1] : r3_q.root[LenW-1:0];
    if (lx_s == '0) lx_s = LenW'(1);
    if (ly_s == '0) ly_s = LenW'(1);
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      FIdle: begin
        if (push) begin
          state_d = FSq;
          cnt_d   = '0;
        end
      end
      FSq: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd3) begin
          state_d = FRoot;
          cnt_d   = RootLast;
        end
      end
      FRoot: begin
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) state_d = FScale;
      end
      FScale: begin
        cnt_d   = '0;
        state_d = degen ? FPush : FMul;
      end
      FMul: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd2) state_d = FPush;
      end
      FPush: begin
        if (elem_ready_i) state_d = FIdle;
      end
      default: state_d = FIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      FIdle: begin
        if (push) begin
          dx1_q <= abs_diff(item_i.corner1_x, item_i.corner0_x);
          dy1_q <= abs_diff(item_i.corner1_y, item_i.corner0_y);
          dx3_q <= abs_diff(item_i.corner3_x, item_i.corner0_x);
          dy3_q <= abs_diff(item_i.corner3_y, item_i.corner0_y);
          k_q   <= {item_i.coeff_3, item_i.coeff_2, item_i.coeff_1, item_i.coeff_0};
        end
      end
      FSq: begin
        r1_q <= '0;
        r3_q <= '0;
        case (cnt_q[1:0])
          2'd0:    s1_q <= prod;
          2'd1:    s1_q <= s1_q + prod;
          2'd2:    s3_q <= prod;
          default: s3_q <= s3_q + prod;
        endcase
      end
      FRoot: begin
        r1_q <= root_step(r1_q, s1_q[SqW-1 -: 2]);
        r3_q <= root_step(r3_q, s3_q[SqW-1 -: 2]);
        s1_q <= s1_q << 2;
        s3_q <= s3_q << 2;
      end
      FScale: begin
        lx_q    <= lx_s;
        ly_q    <= ly_s;
        degen_q <= degen;
      end
      FMul: begin
        case (cnt_q[1:0])
          2'd0:    xsq_q <= prod[ProdW-1:0];
          2'd1:    ysq_q <= prod[ProdW-1:0];
          default: d_q   <= prod[ProdW-1:0];
        endcase
      end
      default: ;
    endcase
  end

  assign full         = (state_q != FIdle);
  assign elem_valid_o = (state_q == FPush);

  always_comb begin
    elem_o.degen = degen_q;
    elem_o.x_sq  = xsq_q;
    elem_o.y_sq  = ysq_q;
    elem_o.d24   = (D24W'(d_q) << 4) + (D24W'(d_q) << 3);
    elem_o.k     = k_q;
  end

endmodule

// ===== sv/bsem_fifo.sv =====
// ----------------------------------------------------------------------------
// bsem_fifo
// Two-entry queue of element geometry between the front and the back.
// ----------------------------------------------------------------------------
module bsem_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  bsem_pkg::elem_t wr_data_i,
  output logic            rd_valid_o,
  input  logic            rd_pop_i,
  output bsem_pkg::elem_t rd_data_o
);
  import bsem_pkg::*;

  elem_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_pop_i && rd_valid_o;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) wr_ptr_q <= ~wr_ptr_q;
      if (rd_en) rd_ptr_q <= ~rd_ptr_q;
      if (wr_en && !rd_en) cnt_q <= cnt_q + 2'd1;
      else if (rd_en && !wr_en) cnt_q <= cnt_q - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

// ===== sv/bsem_lane.sv =====
// ----------------------------------------------------------------------------
// bsem_lane
// One matrix column: shift-add product of the weights, then restoring divide.
// ----------------------------------------------------------------------------
module bsem_lane (
  input  logic                          clk_i,
  input  bsem_pkg::lane_ctrl_t          ctrl_i,
  input  logic [bsem_pkg::CoefW-1:0]    coef_a_i,
  input  logic [bsem_pkg::CoefW-1:0]    coef_b_i,
  input  logic [bsem_pkg::ProdW-1:0]    x_sq_i,
  input  logic [bsem_pkg::ProdW-1:0]    y_sq_i,
  input  logic [bsem_pkg::D24W-1:0]     d24_i,
  output logic [bsem_pkg::DataW-1:0]    entry_o,
  output logic                          sat_o
);
  import bsem_pkg::*;

  logic [CoefW-1:0] a_q, b_q;
  logic [AccW-1:0]  acc_q;
  logic             neg_q, ovf_q;
  logic [D24W-1:0]  rem_q;
  logic [DataW-1:0] low_q, quo_q;

  logic [AccW-1:0]  xa, yb, acc_base, acc_next, mag;
  logic [MagW-1:0]  m;
  logic [D24W:0]    t, t_sub;
  logic             ge;

  // msb-first accumulate, sign bit weighs negative
  always_comb begin
    xa       = a_q[CoefW-1] ? AccW'(x_sq_i) : '0;
    yb       = b_q[CoefW-1] ? AccW'(y_sq_i) : '0;
    acc_base = ctrl_i.first ? '0 : (acc_q << 1);
    acc_next = ctrl_i.first ? (acc_base - xa - yb) : (acc_base + xa + yb);
    mag      = acc_q[AccW-1] ? (~acc_q + AccW'(1)) : acc_q;
    m        = mag[MagW-1:0];
  end

  // one quotient bit
  always_comb begin
    t     = {rem_q, low_q[DataW-1]};
    t_sub = t - {1'b0, d24_i};
    ge    = (t >= {1'b0, d24_i});
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      a_q <= coef_a_i;
      b_q <= coef_b_i;
    end
    if (ctrl_i.mul) begin
      acc_q <= acc_next;
      a_q   <= a_q << 1;
      b_q   <= b_q << 1;
    end
    if (ctrl_i.prep) begin
      neg_q <= acc_q[AccW-1];
      ovf_q <= (m[MagW-1:DataW] >= d24_i);
      rem_q <= m[MagW-1:DataW];
      low_q <= m[DataW-1:0];
    end
    if (ctrl_i.div) begin
      rem_q <= ge ? t_sub[D24W-1:0] : t[D24W-1:0];
      low_q <= low_q << 1;
      quo_q <= {quo_q[DataW-2:0], ge};
    end
  end

  // sign and clipping
  always_comb begin
    sat_o = ovf_q || (neg_q ? (quo_q[DataW-1] && (|quo_q[DataW-2:0])) : quo_q[DataW-1]);
    if (sat_o) entry_o = neg_q ? MinNeg : MaxPos;
    else       entry_o = neg_q ? (~quo_q + DataW'(1)) : quo_q;
  end

endmodule

// ===== sv/bsem_back.sv =====
// ----------------------------------------------------------------------------
// bsem_back
// Walks the four rows of the queued element and holds the result register.
// ----------------------------------------------------------------------------
module bsem_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  bsem_pkg::elem_t   head_i,
  output logic              head_pop_o,
  output logic              empty,
  input  logic              pop,
  output bsem_pkg::result_t result_o
);
  import bsem_pkg::*;

  localparam logic [2:0] BIdle = 3'd0;
  localparam logic [2:0] BMul  = 3'd1;
  localparam logic [2:0] BPrep = 3'd2;
  localparam logic [2:0] BDiv  = 3'd3;
  localparam logic [2:0] BDone = 3'd4;

  localparam logic [5:0] MulLast = 6'(CoefW - 1);
  localparam logic [5:0] DivLast = 6'(DataW - 1);

  logic [2:0]       state_q, state_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [1:0]       row_q, row_d;
  logic             out_valid_q, out_valid_d;
  result_t          out_q;
  result_t          row_res;
  lane_ctrl_t       ctrl;
  logic             load_out;
  logic [DataW-1:0] entry [4];
  logic [3:0]       sat;

  // lane control
  always_comb begin
    ctrl.load  = (state_q == BIdle) && head_valid_i && !head_i.degen;
    ctrl.mul   = (state_q == BMul);
    ctrl.first = (state_q == BMul) && (cnt_q == MulLast);
    ctrl.prep  = (state_q == BPrep);
    ctrl.div   = (state_q == BDiv);
  end

  for (genvar c = 0; c < 4; c++) begin : g_lane
    bsem_lane u_lane (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .coef_a_i (wsum(row_q, 2'(c), head_i.k, 1'b0)),
      .coef_b_i (wsum(row_q, 2'(c), head_i.k, 1'b1)),
      .x_sq_i   (head_i.x_sq),
      .y_sq_i   (head_i.y_sq),
      .d24_i    (head_i.d24),
      .entry_o  (entry[c]),
      .sat_o    (sat[c])
    );
  end

  assign load_out   = (state_q == BDone) && (!out_valid_q || pop);
  assign head_pop_o = load_out && (row_q == 2'd3);

  // row sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    row_d   = row_q;
    case (state_q)
      BIdle: begin
        cnt_d = MulLast;
        if (head_valid_i) state_d = head_i.degen ? BDone : BMul;
      end
      BMul: begin
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) state_d = BPrep;
      end
      BPrep: begin
        cnt_d   = DivLast;
        state_d = BDiv;
      end
      BDiv: begin
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) state_d = BDone;
      end
      BDone: begin
        if (load_out) begin
          state_d = BIdle;
          row_d   = row_q + 2'd1;
        end
      end
      default: state_d = BIdle;
    endcase
  end

  // row result
  always_comb begin
    row_res.row_index  = row_q;
    row_res.entry_0    = head_i.degen ? '0 : entry[0];
    row_res.entry_1    = head_i.degen ? '0 : entry[1];
    row_res.entry_2    = head_i.degen ? '0 : entry[2];
    row_res.entry_3    = head_i.degen ? '0 : entry[3];
    row_res.degenerate = head_i.degen;
    row_res.saturated  = !head_i.degen && (|sat);
    row_res.last_row   = (row_q == 2'd3);
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out)                 out_valid_d = 1'b1;
    else if (pop && out_valid_q)  out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BIdle;
      cnt_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) out_q <= row_res;
  end

  assign empty    = !out_valid_q;
  assign result_o = out_q;

endmodule

// ===== sv/bilinear_stiffness_element_matrix_top.sv =====
// ----------------------------------------------------------------------------
// bilinear_stiffness_element_matrix_top
// Bilinear quad element stiffness matrix, one matrix row per result.
// ----------------------------------------------------------------------------
// Usage: an element request is written with push while full is low; it carries
// corners 0, 1 and 3 and the four nodal coefficients, all signed Q16.16.
// Each element yields four results, rows 0 to 3 in order, read from result_o
// while empty is low and taken with pop. last_row marks row 3.
// The front squares and sums the coordinate differences, runs the
// two-bit-per-cycle square root, scales, and forms lx^2, ly^2 and lx*ly;
// the back spends per row 36 shift-add steps for A*lx^2 + B*ly^2, 32
// restoring divide steps by 24*lx*ly, plus the idle, prep and done states,
// four columns in parallel lanes. Sustained rate is set by the shift-add
// and divide loops of the lanes. A degenerate element skips those loops;
// each of its rows goes straight from idle to done in the back.
// A two-entry queue sits between front and back, so the front takes the next
// element while the back still works or waits on a stalled result.
// Reset empties the queue and the result register. When pop stays low the
// current row holds and the back, then the queue, then full back up.
// ----------------------------------------------------------------------------
module bilinear_stiffness_element_matrix_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  bsem_pkg::item_t   item_i,
  output logic              empty,
  input  logic              pop,
  output bsem_pkg::result_t result_o
);
  import bsem_pkg::*;

  logic  fe_valid, fe_ready, q_valid, q_pop;
  elem_t fe_elem, q_elem;

  // length and product front end
  bsem_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .item_i       (item_i),
    .elem_valid_o (fe_valid),
    .elem_ready_i (fe_ready),
    .elem_o       (fe_elem)
  );

  // decoupling queue
  bsem_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fe_valid),
    .wr_ready_o (fe_ready),
    .wr_data_i  (fe_elem),
    .rd_valid_o (q_valid),
    .rd_pop_i   (q_pop),
    .rd_data_o  (q_elem)
  );

  // row engine and result register
  bsem_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (q_elem),
    .head_pop_o   (q_pop),
    .empty        (empty),
    .pop          (pop),
    .result_o     (result_o)
  );

endmodule

// ===== sv/bsem_checker.sv =====
// ----------------------------------------------------------------------------
// bsem_checker
// Port-level checks for the element matrix block, bound to the top level.
// ----------------------------------------------------------------------------
module bsem_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              push,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input bsem_pkg::result_t result_o
);
  import bsem_pkg::*;

  // no result shown while in reset
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result shown during reset");

  // a taken request keeps the front busy on the next cycle
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> full)
    else $error("full low right after a request");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("stalled result changed");

  // last row flag tracks the row index
  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.last_row == (result_o.row_index == 2'd3)))
    else $error("last_row does not match row_index");

  // degenerate rows are zero and never clipped
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.degenerate) |->
      (result_o.entry_0 == '0 && result_o.entry_1 == '0 && result_o.entry_2 == '0 &&
       result_o.entry_3 == '0 && !result_o.saturated))
    else $error("degenerate row carries data");

endmodule

bind bilinear_stiffness_element_matrix_top bsem_checker u_bsem_checker (.*);
